FILE: hdl/vqls_pkg.sv
`timescale 1ns / 1ps
package vqls_pkg;

  localparam int BITRATE_W = 32;
  localparam int DIM_W     = 14;
  localparam int IDX_W     = 4;
  localparam int FPS_W     = 6;
  localparam int VFPS_W    = 8;
  localparam int PRIO_W    = 2;
  localparam int ROM_RUNGS = 16;
  localparam int RDIM_W    = 12;
  localparam int THR_W     = 24;
  localparam int PIX_W     = 24;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [2:0] {
    REG_MIN_BITRATE  = 3'd0,
    REG_PEER_CEILING = 3'd1,
    REG_VIEWER_RATE  = 3'd2,
    REG_VIEWER_FPS   = 3'd3,
    REG_VIEWER_HT    = 3'd4,
    REG_PRIORITY     = 3'd5
  } cfg_reg_e;

  localparam logic [PRIO_W-1:0] PRIO_BALANCED  = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_FRAMERATE = 2'd1;
  localparam logic [PRIO_W-1:0] PRIO_PIXELS    = 2'd2;

  localparam logic [BITRATE_W-1:0] MIN_BITRATE_RST  = 32'd150000;
  localparam logic [BITRATE_W-1:0] PEER_CEILING_RST = 32'd15000000;
  localparam logic [VFPS_W-1:0]    DEFAULT_FPS_CAP  = 8'd30;

  typedef struct packed {
    logic [RDIM_W-1:0] w;
    logic [RDIM_W-1:0] h;
    logic [FPS_W-1:0]  fps;
    logic [THR_W-1:0]  thr;
    logic [PIX_W-1:0]  pix;
  } rung_t;

  function automatic rung_t rung_f(input logic [IDX_W-1:0] idx);
    rung_t r;
    unique case (idx)
      4'd0:  r = '{12'd3840, 12'd2160, 6'd30, 24'd15000000, 24'd8294400};
      4'd1:  r = '{12'd2560, 12'd1440, 6'd60, 24'd14000000, 24'd3686400};
      4'd2:  r = '{12'd3840, 12'd2160, 6'd15, 24'd12000000, 24'd8294400};
      4'd3:  r = '{12'd2560, 12'd1440, 6'd30, 24'd10000000, 24'd3686400};
      4'd4:  r = '{12'd1920, 12'd1080, 6'd60, 24'd9000000,  24'd2073600};
      4'd5:  r = '{12'd1920, 12'd1080, 6'd30, 24'd6000000,  24'd2073600};
      4'd6:  r = '{12'd1280, 12'd720,  6'd60, 24'd4800000,  24'd921600};
      4'd7:  r = '{12'd1600, 12'd900,  6'd30, 24'd4500000,  24'd1440000};
      4'd8:  r = '{12'd1280, 12'd720,  6'd30, 24'd3000000,  24'd921600};
      4'd9:  r = '{12'd1280, 12'd720,  6'd15, 24'd1800000,  24'd921600};
      4'd10: r = '{12'd960,  12'd540,  6'd30, 24'd1600000,  24'd518400};
      4'd11: r = '{12'd960,  12'd540,  6'd15, 24'd1000000,  24'd518400};
      4'd12: r = '{12'd640,  12'd360,  6'd30, 24'd700000,   24'd230400};
      4'd13: r = '{12'd1280, 12'd720,  6'd10, 24'd450000,   24'd921600};
      4'd14: r = '{12'd960,  12'd540,  6'd10, 24'd380000,   24'd518400};
      4'd15: r = '{12'd640,  12'd360,  6'd5,  24'd350000,   24'd230400};
      default: r = '{12'd640, 12'd360, 6'd5, 24'd350000, 24'd230400};
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/vqls_if.sv
`timescale 1ns / 1ps
interface vqls_in_if import vqls_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [BITRATE_W-1:0] target_bitrate;
  logic [DIM_W-1:0]     src_width;
  logic [DIM_W-1:0]     src_height;

  modport source (output valid, target_bitrate, src_width, src_height, input ready);
  modport sink   (input valid, target_bitrate, src_width, src_height, output ready);
endinterface

interface vqls_out_if import vqls_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [IDX_W-1:0]     rung_index;
  logic [DIM_W-1:0]     out_width;
  logic [DIM_W-1:0]     out_height;
  logic [FPS_W-1:0]     out_fps;
  logic [BITRATE_W-1:0] out_bitrate;

  modport source (output valid, rung_index, out_width, out_height, out_fps, out_bitrate,
                  input ready);
  modport sink   (input valid, rung_index, out_width, out_height, out_fps, out_bitrate,
                  output ready);
endinterface

FILE: hdl/video_quality_ladder_select.sv
`timescale 1ns / 1ps
// Video quality ladder select: takes one word (target bitrate, source width and
// height) and returns one encode setting word (rung index, even scaled width and
// height, rung frame rate, clamped bitrate). The bitrate is clamped between the
// floor and the ceiling (viewer cap if set), then the first min(LADDER_DEPTH, 16)
// rungs of a fixed ROM ladder are walked one rung per cycle under the priority
// mode, falling back to the last rung walked. The source is scaled by the
// smaller of 1 and the rung/source ratios using one shared 14x14 multiplier and
// a restoring divider that retires one quotient bit per cycle. When no scaling
// is needed the 26-step divide is skipped. The input is not ready from
// acceptance until the result word is in the output register. The result
// sits in an output register, so a new word is taken while it waits.
// Configuration is an APB slave: registers at byte offsets 0 (floor bitrate),
// 4 (peer ceiling), 8 (viewer bitrate cap), 12 (viewer fps cap), 16 (viewer
// height cap) and 20 (priority mode); pready is tied high.
module video_quality_ladder_select import vqls_pkg::*; #(
  parameter int LADDER_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  vqls_in_if.sink           in_i,
  vqls_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int N_EFF = (LADDER_DEPTH < ROM_RUNGS) ? LADDER_DEPTH : ROM_RUNGS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_EFF - 1);
  localparam int PROD_W = 2 * DIM_W;
  localparam int DVD_W  = DIM_W + RDIM_W;
  localparam int CNT_W  = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CEIL, S_RATE, S_WALK, S_PICK, S_SCL1, S_SCL2, S_LOAD, S_DIV, S_FIN
  } state_e;

  typedef enum logic [1:0] {
    SC_NONE, SC_W, SC_H
  } scale_e;

  // configuration registers
  logic [BITRATE_W-1:0] min_q, peer_q, vmb_q;
  logic [VFPS_W-1:0]    vfps_q;
  logic [DIM_W-1:0]     vmh_q;
  logic [PRIO_W-1:0]    prio_q;

  // datapath
  state_e               state_q;
  logic [BITRATE_W-1:0] target_q, ceil_q, rate_q;
  logic [DIM_W-1:0]     sw_q, sh_q;
  logic [PROD_W-1:0]    spix_q, prod_q;
  logic [IDX_W-1:0]     idx_q, sel_q;
  logic                 f_found_q, m1_found_q, m2_found_q;
  logic [IDX_W-1:0]     f_idx_q, m1_idx_q, m2_idx_q;
  logic [PIX_W-1:0]     m2_pix_q;
  logic [FPS_W-1:0]     m2_fps_q;
  logic [RDIM_W-1:0]    rw_q, rh_q;
  logic [FPS_W-1:0]     rfps_q;
  logic                 wless_q;
  scale_e               scase_q;
  logic [DIM_W-1:0]     other_q, den_q;
  logic [RDIM_W-1:0]    num_q;
  logic [DVD_W-1:0]     quo_q;
  logic [DIM_W:0]       rem_q;
  logic [CNT_W-1:0]     cnt_q;

  // output register
  logic                 out_valid_q;
  logic [IDX_W-1:0]     o_idx_q;
  logic [DIM_W-1:0]     o_w_q, o_h_q;
  logic [FPS_W-1:0]     o_fps_q;
  logic [BITRATE_W-1:0] o_rate_q;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= MIN_BITRATE_RST;
      peer_q <= PEER_CEILING_RST;
      vmb_q  <= '0;
      vfps_q <= '0;
      vmh_q  <= '0;
      prio_q <= PRIO_BALANCED;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_MIN_BITRATE:  min_q  <= pwdata;
        REG_PEER_CEILING: peer_q <= pwdata;
        REG_VIEWER_RATE:  vmb_q  <= pwdata;
        REG_VIEWER_FPS:   vfps_q <= pwdata[VFPS_W-1:0];
        REG_VIEWER_HT:    vmh_q  <= pwdata[DIM_W-1:0];
        REG_PRIORITY:     prio_q <= pwdata[PRIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MIN_BITRATE:  prdata = min_q;
      REG_PEER_CEILING: prdata = peer_q;
      REG_VIEWER_RATE:  prdata = vmb_q;
      REG_VIEWER_FPS:   prdata = APB_DW'(vfps_q);
      REG_VIEWER_HT:    prdata = APB_DW'(vmh_q);
      REG_PRIORITY:     prdata = APB_DW'(prio_q);
      default:          prdata = '0;
    endcase
  end

  function automatic logic [BITRATE_W-1:0] clamp_f(input logic [BITRATE_W-1:0] x,
                                                   input logic [BITRATE_W-1:0] lo,
                                                   input logic [BITRATE_W-1:0] hi);
    logic [BITRATE_W-1:0] r;
    if (x < lo)      r = lo;
    else if (x > hi) r = hi;
    else             r = x;
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] even2_f(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] e;
    e = {v[DIM_W-1:1], 1'b0};
    return (e < DIM_W'(2)) ? DIM_W'(2) : e;
  endfunction

  // shared multiplier
  logic [DIM_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  always_comb begin
    unique case (state_q)
      S_SCL1:  begin mul_a = DIM_W'(rh_q); mul_b = sw_q; end
      S_SCL2:  begin mul_a = DIM_W'(rw_q); mul_b = sh_q; end
      S_LOAD:  begin mul_a = other_q;      mul_b = DIM_W'(num_q); end
      default: begin mul_a = sw_q;         mul_b = sh_q; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // rung under test and its eligibility
  logic [VFPS_W-1:0] fps_cap, fps_want;
  rung_t             cur;
  logic              cur_ok;
  assign fps_cap  = (vfps_q != '0) ? vfps_q : DEFAULT_FPS_CAP;
  assign fps_want = (fps_cap < DEFAULT_FPS_CAP) ? fps_cap : DEFAULT_FPS_CAP;
  assign cur      = rung_f(idx_q);
  assign cur_ok   = (rate_q >= BITRATE_W'(cur.thr)) &&
                    (PROD_W'(cur.pix) <= spix_q) &&
                    (VFPS_W'(cur.fps) <= fps_cap) &&
                    ((vmh_q == '0) || (DIM_W'(cur.h) <= vmh_q));

  // rung choice at the end of the walk
  logic [IDX_W-1:0] pick_idx;
  rung_t            pick;
  always_comb begin
    if (prio_q == PRIO_FRAMERATE && m1_found_q)   pick_idx = m1_idx_q;
    else if (prio_q == PRIO_PIXELS && m2_found_q) pick_idx = m2_idx_q;
    else if (f_found_q)                           pick_idx = f_idx_q;
    else                                          pick_idx = LAST_IDX;
  end
  assign pick = rung_f(pick_idx);

  // divider step
  logic [DIM_W:0] trial;
  logic           fits;
  assign trial = {rem_q[DIM_W-1:0], quo_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  logic hless;
  assign hless = wless_q ? (prod_q < mul_p) : (DIM_W'(rh_q) < sh_q);

  logic [DIM_W-1:0] res_w, res_h;
  always_comb begin
    unique case (scase_q)
      SC_W:    begin res_w = DIM_W'(rw_q);          res_h = quo_q[DIM_W-1:0]; end
      SC_H:    begin res_w = quo_q[DIM_W-1:0];      res_h = DIM_W'(rh_q); end
      default: begin res_w = sw_q;                  res_h = sh_q; end
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      f_found_q   <= 1'b0;
      m1_found_q  <= 1'b0;
      m2_found_q  <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
      scase_q     <= SC_NONE;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != S_FIN)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            // hold the word, lifting sides below 2 up to 2
            target_q <= in_i.target_bitrate;
            sw_q     <= (in_i.src_width  < DIM_W'(2)) ? DIM_W'(2) : in_i.src_width;
            sh_q     <= (in_i.src_height < DIM_W'(2)) ? DIM_W'(2) : in_i.src_height;
            state_q  <= S_CEIL;
          end
        end
        S_CEIL: begin
          ceil_q  <= (vmb_q != '0) ? clamp_f(vmb_q, min_q, peer_q) : peer_q;
          spix_q  <= mul_p;
          state_q <= S_RATE;
        end
        S_RATE: begin
          rate_q     <= clamp_f(target_q, min_q, ceil_q);
          idx_q      <= '0;
          f_found_q  <= 1'b0;
          m1_found_q <= 1'b0;
          m2_found_q <= 1'b0;
          state_q    <= S_WALK;
        end
        S_WALK: begin
          // track first eligible, first at wanted fps and largest picture at once
          if (cur_ok && !f_found_q) begin
            f_found_q <= 1'b1;
            f_idx_q   <= idx_q;
          end
          if (cur_ok && !m1_found_q && (VFPS_W'(cur.fps) >= fps_want)) begin
            m1_found_q <= 1'b1;
            m1_idx_q   <= idx_q;
          end
          if (cur_ok && (!m2_found_q || cur.pix > m2_pix_q ||
                         (cur.pix == m2_pix_q && cur.fps > m2_fps_q))) begin
            m2_found_q <= 1'b1;
            m2_idx_q   <= idx_q;
            m2_pix_q   <= cur.pix;
            m2_fps_q   <= cur.fps;
          end
          if (idx_q == LAST_IDX) state_q <= S_PICK;
          else                   idx_q   <= idx_q + IDX_W'(1);
        end
        S_PICK: begin
          sel_q   <= pick_idx;
          rw_q    <= pick.w;
          rh_q    <= pick.h;
          rfps_q  <= pick.fps;
          state_q <= S_SCL1;
        end
        S_SCL1: begin
          prod_q  <= mul_p;
          wless_q <= DIM_W'(rw_q) < sw_q;
          state_q <= S_SCL2;
        end
        S_SCL2: begin
          // height ratio wins only when strictly smaller than the current scale
          if (hless) begin
            scase_q <= SC_H;
            num_q   <= rh_q;
            den_q   <= sh_q;
            other_q <= sw_q;
          end else if (wless_q) begin
            scase_q <= SC_W;
            num_q   <= rw_q;
            den_q   <= sw_q;
            other_q <= sh_q;
          end else begin
            scase_q <= SC_NONE;
            num_q   <= rw_q;
            den_q   <= sw_q;
            other_q <= sh_q;
          end
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          quo_q   <= mul_p[DVD_W-1:0];
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= (scase_q == SC_NONE) ? S_FIN : S_DIV;
        end
        S_DIV: begin
          rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
          quo_q <= {quo_q[DVD_W-2:0], fits};
          if (cnt_q == DIV_LAST) state_q <= S_FIN;
          else                   cnt_q   <= cnt_q + CNT_W'(1);
        end
        S_FIN: begin
          // drop the result into the output register once it is free
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            o_idx_q     <= sel_q;
            o_w_q       <= even2_f(res_w);
            o_h_q       <= even2_f(res_h);
            o_fps_q     <= rfps_q;
            o_rate_q    <= rate_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.rung_index  = o_idx_q;
  assign out_o.out_width   = o_w_q;
  assign out_o.out_height  = o_h_q;
  assign out_o.out_fps     = o_fps_q;
  assign out_o.out_bitrate = o_rate_q;

endmodule

FILE: verif/vqls_checker.sv
`timescale 1ns / 1ps
// Watches the request and setting channels and the register port, predicts
// each encode setting from its own register copy and compares in order.
module vqls_checker import vqls_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  vqls_in_if                in_i,
  vqls_out_if               out_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int                fail_count_o,
  output int                owed_o
);

  typedef struct packed {
    logic [IDX_W-1:0]     rung;
    logic [DIM_W-1:0]     w;
    logic [DIM_W-1:0]     h;
    logic [FPS_W-1:0]     fps;
    logic [BITRATE_W-1:0] rate;
  } setting_t;

  typedef struct {
    int unsigned w;
    int unsigned h;
    int unsigned fps;
    int unsigned thr;
  } ladder_rung_t;

  localparam int MAX_PRINTS = 100;

  logic [BITRATE_W-1:0] floor_rate;
  logic [BITRATE_W-1:0] peer_ceiling;
  logic [BITRATE_W-1:0] viewer_rate;
  logic [VFPS_W-1:0]    viewer_fps;
  logic [DIM_W-1:0]     viewer_lines;
  logic [PRIO_W-1:0]    prio;

  setting_t settings_owed[$];
  setting_t due;
  logic     took;
  logic     gave;

  function automatic ladder_rung_t ladder_rung(input int k);
    ladder_rung_t r;
    case (k)
      0:       r = '{3840, 2160, 30, 15000000};
      1:       r = '{2560, 1440, 60, 14000000};
      2:       r = '{3840, 2160, 15, 12000000};
      3:       r = '{2560, 1440, 30, 10000000};
      4:       r = '{1920, 1080, 60, 9000000};
      5:       r = '{1920, 1080, 30, 6000000};
      6:       r = '{1280, 720, 60, 4800000};
      7:       r = '{1600, 900, 30, 4500000};
      8:       r = '{1280, 720, 30, 3000000};
      9:       r = '{1280, 720, 15, 1800000};
      10:      r = '{960, 540, 30, 1600000};
      11:      r = '{960, 540, 15, 1000000};
      12:      r = '{640, 360, 30, 700000};
      13:      r = '{1280, 720, 10, 450000};
      14:      r = '{960, 540, 10, 380000};
      default: r = '{640, 360, 5, 350000};
    endcase
    return r;
  endfunction

  function automatic logic [BITRATE_W-1:0] clamp_rate(input logic [BITRATE_W-1:0] x,
      input logic [BITRATE_W-1:0] lo, input logic [BITRATE_W-1:0] hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic logic [DIM_W-1:0] even_side(input logic [63:0] v);
    logic [63:0] e;
    e = v & ~64'd1;
    return (e < 2) ? DIM_W'(2) : e[DIM_W-1:0];
  endfunction

  function automatic setting_t predict_setting(input logic [BITRATE_W-1:0] target,
      input logic [DIM_W-1:0] w_in, input logic [DIM_W-1:0] h_in);
    logic [BITRATE_W-1:0] ceiling;
    logic [BITRATE_W-1:0] rate;
    logic [63:0]          sw, sh, spix, num, den;
    logic [63:0]          pix_of[ROM_RUNGS];
    int unsigned          fps_of[ROM_RUNGS];
    bit                   ok[ROM_RUNGS];
    int unsigned          fps_cap, wanted;
    int                   n, sel;
    ladder_rung_t         r;
    setting_t             s;
    ceiling = peer_ceiling;
    if (viewer_rate != 0) ceiling = clamp_rate(viewer_rate, floor_rate, peer_ceiling);
    rate = clamp_rate(target, floor_rate, ceiling);
    sw = (w_in < 2) ? 64'd2 : 64'(w_in);
    sh = (h_in < 2) ? 64'd2 : 64'(h_in);
    spix = sw * sh;
    fps_cap = (viewer_fps != 0) ? viewer_fps : 30;
    n = (DEPTH < ROM_RUNGS) ? DEPTH : ROM_RUNGS;
    sel = -1;
    for (int k = 0; k < n; k++) begin
      r = ladder_rung(k);
      pix_of[k] = 64'(r.w) * 64'(r.h);
      fps_of[k] = r.fps;
      ok[k] = rate >= r.thr && pix_of[k] <= spix && r.fps <= fps_cap &&
              (viewer_lines == 0 || r.h <= viewer_lines);
    end
    case (prio)
      PRIO_FRAMERATE: begin
        wanted = (fps_cap < 30) ? fps_cap : 30;
        for (int k = 0; k < n; k++)
          if (sel < 0 && ok[k] && fps_of[k] >= wanted) sel = k;
      end
      PRIO_PIXELS: begin
        for (int k = 0; k < n; k++)
          if (ok[k] && (sel < 0 || pix_of[k] > pix_of[sel] ||
                        (pix_of[k] == pix_of[sel] && fps_of[k] > fps_of[sel])))
            sel = k;
      end
      default: ;
    endcase
    for (int k = 0; k < n; k++)
      if (sel < 0 && ok[k]) sel = k;
    if (sel < 0) sel = n - 1;
    r = ladder_rung(sel);
    // scale is num/den, the least of 1 and the two rung/source ratios
    num = 1;
    den = 1;
    if (64'(r.w) * den < num * sw) begin
      num = r.w;
      den = sw;
    end
    if (64'(r.h) * den < num * sh) begin
      num = r.h;
      den = sh;
    end
    s.rung = IDX_W'(sel);
    s.w    = even_side(sw * num / den);
    s.h    = even_side(sh * num / den);
    s.fps  = FPS_W'(r.fps);
    s.rate = rate;
    return s;
  endfunction

  task automatic report_fail(input string msg);
    if (fail_count_o < MAX_PRINTS) $display("ERROR at %0t ns: %s", $time, msg);
    fail_count_o = fail_count_o + 1;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
      input logic [31:0] want);
    if (got !== want) report_fail($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_rate   <= MIN_BITRATE_RST;
      peer_ceiling <= PEER_CEILING_RST;
      viewer_rate  <= '0;
      viewer_fps   <= '0;
      viewer_lines <= '0;
      prio         <= PRIO_BALANCED;
      owed_o       <= 0;
      fail_count_o <= 0;
      settings_owed.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_e'(paddr[APB_AW-1:2]))
          REG_MIN_BITRATE:  floor_rate   <= pwdata;
          REG_PEER_CEILING: peer_ceiling <= pwdata;
          REG_VIEWER_RATE:  viewer_rate  <= pwdata;
          REG_VIEWER_FPS:   viewer_fps   <= pwdata[VFPS_W-1:0];
          REG_VIEWER_HT:    viewer_lines <= pwdata[DIM_W-1:0];
          REG_PRIORITY:     prio         <= pwdata[PRIO_W-1:0];
          default: ;
        endcase
      end
      took = in_i.valid && in_i.ready;
      gave = out_i.valid && out_i.ready;
      if (took)
        settings_owed.push_back(predict_setting(in_i.target_bitrate, in_i.src_width,
                                                in_i.src_height));
      if (gave) begin
        if (settings_owed.size() == 0) begin
          report_fail("setting word arrived with nothing owed");
        end else begin
          due = settings_owed.pop_front();
          check_field("rung_index", 32'(out_i.rung_index), 32'(due.rung));
          check_field("out_width", 32'(out_i.out_width), 32'(due.w));
          check_field("out_height", 32'(out_i.out_height), 32'(due.h));
          check_field("out_fps", 32'(out_i.out_fps), 32'(due.fps));
          check_field("out_bitrate", out_i.out_bitrate, due.rate);
        end
      end
      owed_o <= settings_owed.size();
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the ladder select bench. Makes stimulus only: request words on the
// input channel, random back-pressure on the setting channel, and register
// writes between phases. The checker beside the block does all prediction and
// comparison and hands back its failure count and how many settings it owes.
module testbench import vqls_pkg::*; ();

  localparam int LADDER_DEPTH = 16;
  // priority code with no mode of its own; the block must treat it as balanced
  localparam logic [PRIO_W-1:0] PRIO_SPARE = 2'd3;
  localparam int PHASES       = 10;
  localparam int WORDS_PER_PH = 183;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 100;
  localparam int SIDE_IN      = 0;
  localparam int SIDE_OUT     = 1;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                fail_cnt;
  int                owed;
  int                quiet;

  // per side: whether the current stretch runs without idling, and its length
  bit calm[2];
  int run_left[2];

  vqls_in_if  in_if();
  vqls_out_if out_if();

  video_quality_ladder_select #(.LADDER_DEPTH(LADDER_DEPTH)) uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  vqls_checker #(.DEPTH(LADDER_DEPTH)) check_u (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_i         (in_if),
    .out_i        (out_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_cnt),
    .owed_o       (owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Draw the wait before the next word: runs of 10 to 60 words either idle
  // at random between words or not at all.
  function automatic int pick_wait(input int side);
    if (run_left[side] == 0) begin
      run_left[side] = $urandom_range(10, 60);
      calm[side] = ($urandom_range(0, 3) == 0);
    end
    run_left[side]--;
    return calm[side] ? 0 : $urandom_range(0, 8);
  endfunction

  // Rate thresholds of the ladder, used to aim requests at rung boundaries.
  function automatic logic [31:0] rung_floor_rate(input int k);
    case (k)
      0:       return 32'd15000000;
      1:       return 32'd14000000;
      2:       return 32'd12000000;
      3:       return 32'd10000000;
      4:       return 32'd9000000;
      5:       return 32'd6000000;
      6:       return 32'd4800000;
      7:       return 32'd4500000;
      8:       return 32'd3000000;
      9:       return 32'd1800000;
      10:      return 32'd1600000;
      11:      return 32'd1000000;
      12:      return 32'd700000;
      13:      return 32'd450000;
      14:      return 32'd380000;
      default: return 32'd350000;
    endcase
  endfunction

  // Common source sizes, portrait and beyond-4K among them.
  task automatic common_size(input int k, output logic [DIM_W-1:0] w,
      output logic [DIM_W-1:0] h);
    case (k)
      0:       begin w = 640;  h = 360;  end
      1:       begin w = 960;  h = 540;  end
      2:       begin w = 1280; h = 720;  end
      3:       begin w = 1600; h = 900;  end
      4:       begin w = 1920; h = 1080; end
      5:       begin w = 2560; h = 1440; end
      6:       begin w = 3840; h = 2160; end
      7:       begin w = 720;  h = 1280; end
      8:       begin w = 1080; h = 1920; end
      9:       begin w = 4096; h = 2160; end
      default: begin w = 7680; h = 4320; end
    endcase
  endtask

  // Offer one request word and hold it until the block takes it. Returns at
  // the accepting edge with valid still high, so a following word with no
  // gap needs no second assignment in the same step.
  task automatic send_word(input logic [BITRATE_W-1:0] rate, input logic [DIM_W-1:0] w,
      input logic [DIM_W-1:0] h);
    int gap;
    gap = pick_wait(SIDE_IN);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.target_bitrate <= rate;
    in_if.src_width      <= w;
    in_if.src_height     <= h;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic send_random();
    logic [BITRATE_W-1:0] rate;
    logic [DIM_W-1:0]     w, h, t;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: rate = $urandom_range(0, 20000000);
      5:             rate = rung_floor_rate($urandom_range(0, 15)) + $urandom_range(0, 2) - 1;
      6, 7:          rate = $urandom;
      8:             rate = $urandom_range(0, 1) ? '1 : '0;
      default:       rate = $urandom_range(300000, 2000000);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: common_size($urandom_range(0, 10), w, h);
      6: begin
        // nudge a common size off by one so odd sides and near misses occur
        common_size($urandom_range(0, 10), w, h);
        w = w + DIM_W'($urandom_range(0, 2)) - DIM_W'(1);
        h = h + DIM_W'($urandom_range(0, 2)) - DIM_W'(1);
      end
      7, 8: begin
        w = DIM_W'($urandom_range(0, 16383));
        h = DIM_W'($urandom_range(0, 16383));
      end
      default: begin
        // degenerate sides, below the minimum of 2 included
        w = DIM_W'($urandom_range(0, 3));
        h = DIM_W'($urandom_range(0, 16383));
        if ($urandom_range(0, 1)) begin
          t = w;
          w = h;
          h = t;
        end
      end
    endcase
    send_word(rate, w, h);
  endtask

  // Drop valid and hold until every owed setting has come back.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready. psel is
  // left high so writes run back to back; write_all closes the burst.
  task automatic cfg_write(input cfg_reg_e r, input logic [APB_DW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic write_all(input logic [31:0] floor_v, input logic [31:0] peer_v,
      input logic [31:0] vrate_v, input logic [VFPS_W-1:0] vfps_v,
      input logic [DIM_W-1:0] vht_v, input logic [PRIO_W-1:0] prio_v);
    cfg_write(REG_MIN_BITRATE, floor_v);
    cfg_write(REG_PEER_CEILING, peer_v);
    cfg_write(REG_VIEWER_RATE, vrate_v);
    cfg_write(REG_VIEWER_FPS, 32'(vfps_v));
    cfg_write(REG_VIEWER_HT, 32'(vht_v));
    cfg_write(REG_PRIORITY, 32'(prio_v));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic setup_phase(input int ph);
    logic [31:0]       floor_v, peer_v, vrate_v;
    logic [VFPS_W-1:0] vfps_v;
    logic [DIM_W-1:0]  vht_v;
    case (ph)
      // widest open: no floor, top ceiling, fps cap at its maximum
      1: write_all(32'd0, '1, 32'd0, '1, 14'd0, PRIO_FRAMERATE);
      2: write_all(32'd500000, 32'd8000000, 32'd3000000, 8'd60, 14'd1080, PRIO_PIXELS);
      // floor above the ceiling, viewer cap beyond both, spare priority code
      3: write_all(32'd20000000, 32'd1000000, '1, 8'd15, 14'd720, PRIO_SPARE);
      // every value register at its lowest non-default value, priority balanced
      4: write_all(32'd0, 32'd0, 32'd1, 8'd1, 14'd1, PRIO_BALANCED);
      5: write_all('1, '1, '1, 8'd5, '1, PRIO_FRAMERATE);
      default: begin
        case ($urandom_range(0, 3))
          0:       floor_v = 0;
          1:       floor_v = $urandom_range(0, 2000000);
          2:       floor_v = $urandom_range(0, 20000000);
          default: floor_v = $urandom;
        endcase
        case ($urandom_range(0, 3))
          0, 1:    peer_v = $urandom_range(1000000, 20000000);
          2:       peer_v = '1;
          default: peer_v = $urandom;
        endcase
        case ($urandom_range(0, 3))
          0, 1:    vrate_v = 0;
          2:       vrate_v = $urandom_range(0, 20000000);
          default: vrate_v = $urandom;
        endcase
        case ($urandom_range(0, 6))
          0:       vfps_v = 0;
          1:       vfps_v = 5;
          2:       vfps_v = 10;
          3:       vfps_v = 15;
          4:       vfps_v = 30;
          5:       vfps_v = 60;
          default: vfps_v = VFPS_W'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 4))
          0, 1:    vht_v = 0;
          2, 3:    vht_v = DIM_W'(180 * $urandom_range(2, 12));
          default: vht_v = DIM_W'($urandom_range(0, 16383));
        endcase
        write_all(floor_v, peer_v, vrate_v, vfps_v, vht_v, PRIO_W'($urandom_range(0, 3)));
      end
    endcase
  endtask

  // Reset, then directed words under the reset settings, then phases of
  // random words, each behind a fresh register set.
  initial begin
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.target_bitrate = '0;
    in_if.src_width      = '0;
    in_if.src_height     = '0;
    out_if.ready         = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(32'd0, 14'd0, 14'd0);              // below floor, sides below 2
    send_word('1, '1, '1);                       // largest request and source
    send_word(32'd15000000, 14'd3840, 14'd2160); // top rung exactly at threshold
    send_word(32'd14999999, 14'd3840, 14'd2160);
    send_word(32'd350000, 14'd640, 14'd360);     // lowest threshold met
    send_word(32'd349999, 14'd640, 14'd360);     // nothing eligible: fall back
    send_word(32'd5000000, 14'd1, 14'd1);
    send_word(32'd15000000, 14'd3839, 14'd2160); // one column short of the top rung
    send_word(32'd9000000, 14'd1920, 14'd1080);  // 60 fps rung blocked by the cap
    send_word(32'd8000000, 14'd100, 14'd16383);  // height sets the scale
    send_word(32'd8000000, 14'd16383, 14'd100);  // width sets the scale
    send_word(32'd2000000, 14'd3, 14'd3);
    send_word(32'd20000000, 14'd1080, 14'd1920);
    send_word(32'd4800000, 14'd7680, 14'd4320);
    send_word('1, 14'd2, 14'd2);
    send_word(32'd3000000, 14'd16383, 14'd2);
    send_word(32'd3000000, 14'd2, 14'd16383);
    send_word(32'd3000000, 14'd1281, 14'd721);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        settle();
        setup_phase(ph);
      end
      for (int i = 0; i < WORDS_PER_PH; i++) begin
        // once, let the pipeline empty completely mid-phase
        if (ph == 2 && i == WORDS_PER_PH / 2) settle();
        send_random();
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Setting sink: stall at random between words, taking each one offered.
  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      int stall;
      stall = pick_wait(SIDE_OUT);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // Watchdog: end the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (psel && penable && pwrite && pready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end else begin
      quiet <= 0;
    end
  end

endmodule

FILE: video_quality_ladder_select.f
hdl/vqls_pkg.sv
hdl/vqls_if.sv
hdl/video_quality_ladder_select.sv
verif/vqls_checker.sv
verif/testbench.sv
